### hw/rtl/pid_axis_controller_top_assert.svh
// Assertion macros for the PID axis controller.
`ifndef PID_AXIS_CONTROLLER_TOP_ASSERT_SVH
`define PID_AXIS_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define PIDAX_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pid axis controller: same-cycle check failed");

`define PIDAX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pid axis controller: next-cycle check failed");

`else

`define PIDAX_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define PIDAX_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/pidax_pkg.sv
`timescale 1ns / 1ps
package pidax_pkg;

  localparam int DataW = 32;
  localparam int PoleW = 17;
  localparam int OpW   = 33;
  localparam int ProdW = 66;
  localparam int FracW = 16;
  localparam int QW    = ProdW - FracW;
  localparam int WideW = QW + 1;
  localparam int SumW  = DataW + 2;
  localparam int StepW = 3;
  localparam int IdxW  = 3;

  localparam logic [StepW-1:0] StepLoad  = 3'd0;
  localparam logic [StepW-1:0] StepFirst = 3'd1;
  localparam logic [StepW-1:0] StepLast  = 3'd6;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic signed [QW-1:0]    qprod_t;
  typedef logic signed [WideW-1:0] wide_t;

  typedef enum logic [IdxW-1:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_SETPOINT_WEIGHT = 3'd1,
    REG_DERIV_POLE      = 3'd2,
    REG_DERIV_GAIN      = 3'd3,
    REG_INTEG_GAIN      = 3'd4,
    REG_OUTPUT_BIAS     = 3'd5,
    REG_DRIVE_MIN       = 3'd6,
    REG_DRIVE_MAX       = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_LOW  = 2'd1,
    CLAMP_HIGH = 2'd2
  } clamp_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_BETA_REF,
    MUL_POLE_DTERM,
    MUL_KP_W,
    MUL_KD_DM,
    MUL_KI_ERR
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_WEIGHTED,
    ACT_POLE,
    ACT_PROP,
    ACT_DTERM,
    ACT_FINISH
  } act_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    act_t     act;
    jmp_t     jmp;
  } ucode_t;

  // From step 2 on, each step consumes the product issued by the step before it.
  function automatic ucode_t ucode_rom(logic [StepW-1:0] step);
    ucode_t uw;
    case (step)
      3'd0:    uw = '{MUL_NONE,       ACT_LOAD,     JMP_WAIT_IN};
      3'd1:    uw = '{MUL_BETA_REF,   ACT_NONE,     JMP_NEXT};
      3'd2:    uw = '{MUL_POLE_DTERM, ACT_WEIGHTED, JMP_NEXT};
      3'd3:    uw = '{MUL_KP_W,       ACT_POLE,     JMP_NEXT};
      3'd4:    uw = '{MUL_KD_DM,      ACT_PROP,     JMP_NEXT};
      3'd5:    uw = '{MUL_KI_ERR,     ACT_DTERM,    JMP_NEXT};
      3'd6:    uw = '{MUL_NONE,       ACT_FINISH,   JMP_WAIT_OUT};
      default: uw = '{MUL_NONE,       ACT_NONE,     JMP_NEXT};
    endcase
    return uw;
  endfunction

  function automatic wide_t sext_q(q_t v);
    return {{(WideW-DataW){v[DataW-1]}}, v};
  endfunction

  function automatic wide_t sext_qp(qprod_t v);
    return {v[QW-1], v};
  endfunction

  function automatic q_t sat_wide(wide_t v);
    q_t r;
    if (v[WideW-1:DataW-1] == '0 || v[WideW-1:DataW-1] == '1) begin
      r = v[DataW-1:0];
    end else if (v[WideW-1]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

  // Round to nearest, ties toward plus infinity, then drop the fraction.
  function automatic qprod_t qround(logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    t = p + {{(ProdW-FracW){1'b0}}, 1'b1, {(FracW-1){1'b0}}};
    return t[ProdW-1:FracW];
  endfunction

endpackage

### hw/rtl/pidax_sample_if.sv
`timescale 1ns / 1ps
interface pidax_sample_if;
  import pidax_pkg::*;

  logic valid;
  logic ready;
  q_t   reference;
  q_t   measurement;

  modport source (output valid, output reference, output measurement, input ready);
  modport sink (input valid, input reference, input measurement, output ready);
endinterface

### hw/rtl/pidax_result_if.sv
`timescale 1ns / 1ps
interface pidax_result_if;
  import pidax_pkg::*;

  logic   valid;
  logic   ready;
  q_t     drive;
  clamp_t clamp_state;

  modport source (output valid, output drive, output clamp_state, input ready);
  modport sink (input valid, input drive, input clamp_state, output ready);
endinterface

### hw/rtl/pid_axis_controller_top.sv
// Processes one sample at a time: a new input beat is accepted only after the
// previous sample has finished the seven-step microprogram that runs all
// five products through one shared 33 x 33 multiplier.
// A result waiting at the output stalls only the final step of the next sample.
// Synchronous active-high reset loads the register defaults, clears the
// integrator, derivative filter and previous measurement, and empties the output.
`timescale 1ns / 1ps
`include "pid_axis_controller_top_assert.svh"
module pid_axis_controller_top (
  input  logic                                  clk,
  input  logic                                  rst,
  pidax_sample_if.sink                          sample,
  pidax_result_if.source                        result,
  input  logic                                  write_enable,
  input  logic [pidax_pkg::IdxW-1:0]            reg_index,
  input  logic [pidax_pkg::DataW-1:0]           write_data
);
  import pidax_pkg::*;

  q_t               prop_gain;
  q_t               setpoint_weight;
  logic [PoleW-1:0] deriv_pole;
  q_t               deriv_gain;
  q_t               integ_gain;
  q_t               output_bias;
  q_t               drive_min;
  q_t               drive_max;

  q_t                      ref_q;
  q_t                      meas_q;
  q_t                      prev_meas;
  q_t                      integ;
  q_t                      dterm;
  q_t                      w_q;
  q_t                      p_q;
  qprod_t                  acc;
  logic signed [ProdW-1:0] prod;
  logic [StepW-1:0]        step;

  logic   out_valid;
  q_t     out_drive;
  clamp_t out_clamp;

  ucode_t                  uw;
  logic                    out_free;
  logic                    fire;
  logic signed [OpW-1:0]   op_a;
  logic signed [OpW-1:0]   op_b;
  logic signed [ProdW-1:0] prod_next;
  logic signed [DataW:0]   dm_wide;
  logic signed [DataW:0]   err_wide;
  q_t                      dm;
  q_t                      err;
  qprod_t                  qv;
  logic signed [SumW-1:0]  sum;
  q_t                      drive_next;
  clamp_t                  clamp_next;

  assign uw       = ucode_rom(step);
  assign out_free = !out_valid || result.ready;

  always_comb begin
    case (uw.jmp)
      JMP_NEXT:     fire = 1'b1;
      JMP_WAIT_IN:  fire = sample.valid;
      JMP_WAIT_OUT: fire = out_free;
      default:      fire = 1'b0;
    endcase
  end

  assign sample.ready = (uw.jmp == JMP_WAIT_IN);

  assign dm_wide  = {meas_q[DataW-1], meas_q} - {prev_meas[DataW-1], prev_meas};
  assign err_wide = {ref_q[DataW-1], ref_q} - {meas_q[DataW-1], meas_q};
  assign dm       = sat_wide({{(WideW-DataW-1){dm_wide[DataW]}}, dm_wide});
  assign err      = sat_wide({{(WideW-DataW-1){err_wide[DataW]}}, err_wide});

  always_comb begin
    case (uw.mul_sel)
      MUL_BETA_REF: begin
        op_a = {setpoint_weight[DataW-1], setpoint_weight};
        op_b = {ref_q[DataW-1], ref_q};
      end
      MUL_POLE_DTERM: begin
        op_a = {{(OpW-PoleW){1'b0}}, deriv_pole};
        op_b = {dterm[DataW-1], dterm};
      end
      MUL_KP_W: begin
        op_a = {prop_gain[DataW-1], prop_gain};
        op_b = {w_q[DataW-1], w_q};
      end
      MUL_KD_DM: begin
        op_a = {deriv_gain[DataW-1], deriv_gain};
        op_b = {dm[DataW-1], dm};
      end
      MUL_KI_ERR: begin
        op_a = {integ_gain[DataW-1], integ_gain};
        op_b = {err[DataW-1], err};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_next = op_a * op_b;
  assign qv        = qround(prod);

  assign sum = {{(SumW-DataW){p_q[DataW-1]}}, p_q}
             + {{(SumW-DataW){integ[DataW-1]}}, integ}
             + {{(SumW-DataW){dterm[DataW-1]}}, dterm}
             + {{(SumW-DataW){output_bias[DataW-1]}}, output_bias};

  always_comb begin
    if (sum < $signed({{(SumW-DataW){drive_min[DataW-1]}}, drive_min})) begin
      drive_next = drive_min;
      clamp_next = CLAMP_LOW;
    end else if (sum > $signed({{(SumW-DataW){drive_max[DataW-1]}}, drive_max})) begin
      drive_next = drive_max;
      clamp_next = CLAMP_HIGH;
    end else begin
      drive_next = sum[DataW-1:0];
      clamp_next = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= 32'sh0001_0000;
      setpoint_weight <= 32'sh0001_0000;
      deriv_pole      <= '0;
      deriv_gain      <= '0;
      integ_gain      <= '0;
      output_bias     <= '0;
      drive_min       <= {1'b1, {(DataW-1){1'b0}}};
      drive_max       <= {1'b0, {(DataW-1){1'b1}}};
    end else if (write_enable) begin
      case (reg_idx_t'(reg_index))
        REG_PROP_GAIN:       prop_gain       <= write_data;
        REG_SETPOINT_WEIGHT: setpoint_weight <= write_data;
        REG_DERIV_POLE:      deriv_pole      <= write_data[PoleW-1:0];
        REG_DERIV_GAIN:      deriv_gain      <= write_data;
        REG_INTEG_GAIN:      integ_gain      <= write_data;
        REG_OUTPUT_BIAS:     output_bias     <= write_data;
        REG_DRIVE_MIN:       drive_min       <= write_data;
        REG_DRIVE_MAX:       drive_max       <= write_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= StepLoad;
      integ     <= '0;
      dterm     <= '0;
      prev_meas <= '0;
    end else if (fire) begin
      step <= (step == StepLast) ? StepLoad : step + 3'd1;
      case (uw.act)
        ACT_DTERM: dterm <= sat_wide(sext_qp(acc) - sext_qp(qv));
        ACT_FINISH: begin
          integ     <= sat_wide(sext_q(integ) + sext_qp(qv));
          prev_meas <= meas_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prod <= prod_next;
      case (uw.act)
        ACT_LOAD: begin
          ref_q  <= sample.reference;
          meas_q <= sample.measurement;
        end
        ACT_WEIGHTED: w_q <= sat_wide(sext_qp(qv) - sext_q(meas_q));
        ACT_POLE:     acc <= qv;
        ACT_PROP:     p_q <= sat_wide(sext_qp(qv));
        ACT_FINISH: begin
          out_drive <= drive_next;
          out_clamp <= clamp_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && uw.act == ACT_FINISH) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid       = out_valid;
  assign result.drive       = out_drive;
  assign result.clamp_state = out_clamp;

  `PIDAX_ASSERT_NEXT(a_accept_starts_program, clk, rst, sample.valid && sample.ready, step == StepFirst)
  `PIDAX_ASSERT_IMPLY(a_result_from_last_step, clk, rst, $rose(result.valid), $past(step) == StepLast)
  `PIDAX_ASSERT_IMPLY(a_low_clamp_value, clk, rst, result.valid && result.clamp_state == CLAMP_LOW, result.drive == drive_min)
  `PIDAX_ASSERT_IMPLY(a_high_clamp_value, clk, rst, result.valid && result.clamp_state == CLAMP_HIGH, result.drive == drive_max)

endmodule

### verif/pid_drive_checker.sv
`timescale 1ns / 1ps
module pid_drive_checker (
  input  logic                        clk,
  input  logic                        rst,
  pidax_sample_if                     sample,
  pidax_result_if                     result,
  input  logic                        write_enable,
  input  logic [pidax_pkg::IdxW-1:0]  reg_index,
  input  logic [pidax_pkg::DataW-1:0] write_data,
  output int                          mismatches,
  output int                          drives_checked,
  output int                          clamped_low,
  output int                          clamped_high,
  output int                          outstanding
);
  import pidax_pkg::*;

  typedef struct packed {
    q_t     drive;
    clamp_t clamp_state;
  } drive_beat_t;

  localparam int PrintLimit = 40;

  drive_beat_t      expected_drives [$];
  drive_beat_t      head;
  q_t               kp, beta, kd, ki, bias, lo, hi;
  logic [PoleW-1:0] pole;
  longint           integ_acc, dfilt, last_meas;

  // Q16.16 product rounded to nearest, ties toward plus infinity.
  function automatic longint q_mul(longint a, longint b);
    longint p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PrintLimit) begin
      $display("%0t: mismatch on %s at drive beat %0d: got %h, expected %h",
               $realtime, what, drives_checked, got, want);
    end
    mismatches++;
  endtask

  task automatic predict_drive(input q_t r, input q_t m);
    longint      w, p, dm, sum;
    drive_beat_t beat;
    w = clip32(q_mul(beta, r) - m);
    p = clip32(q_mul(kp, w));
    dm = clip32(m - last_meas);
    dfilt = clip32(q_mul(longint'(pole), dfilt) - q_mul(kd, dm));
    sum = p + integ_acc + dfilt + bias;
    if (sum < lo) begin
      beat = '{lo, CLAMP_LOW};
    end else if (sum > hi) begin
      beat = '{hi, CLAMP_HIGH};
    end else begin
      beat = '{q_t'(sum), CLAMP_NONE};
    end
    integ_acc = clip32(integ_acc + q_mul(ki, clip32(r - m)));
    last_meas = m;
    expected_drives.push_back(beat);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kp = 32'sh0001_0000;
      beta = 32'sh0001_0000;
      pole = '0;
      kd = '0;
      ki = '0;
      bias = '0;
      lo = 32'sh8000_0000;
      hi = 32'sh7FFF_FFFF;
      integ_acc = 0;
      dfilt = 0;
      last_meas = 0;
      mismatches = 0;
      drives_checked = 0;
      clamped_low = 0;
      clamped_high = 0;
      expected_drives.delete();
    end else begin
      if (write_enable) begin
        case (reg_index)
          REG_PROP_GAIN:       kp = write_data;
          REG_SETPOINT_WEIGHT: beta = write_data;
          REG_DERIV_POLE:      pole = write_data[PoleW-1:0];
          REG_DERIV_GAIN:      kd = write_data;
          REG_INTEG_GAIN:      ki = write_data;
          REG_OUTPUT_BIAS:     bias = write_data;
          REG_DRIVE_MIN:       lo = write_data;
          REG_DRIVE_MAX:       hi = write_data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("unexpected drive beat", result.drive, '0);
        end else begin
          head = expected_drives.pop_front();
          if (result.drive !== head.drive) begin
            report_mismatch("drive", result.drive, head.drive);
          end
          if (result.clamp_state !== head.clamp_state) begin
            report_mismatch("clamp_state", 32'(result.clamp_state), 32'(head.clamp_state));
          end
          if (head.clamp_state == CLAMP_LOW) begin
            clamped_low++;
          end
          if (head.clamp_state == CLAMP_HIGH) begin
            clamped_high++;
          end
        end
        drives_checked++;
      end
      if (sample.valid && sample.ready) begin
        predict_drive(sample.reference, sample.measurement);
      end
    end
    outstanding <= expected_drives.size();
  end

endmodule

### verif/pid_axis_controller_top_tb.sv
`timescale 1ns / 1ps
module pid_axis_controller_top_tb;
  import pidax_pkg::*;

  localparam int IdleLimit    = 5000;
  localparam int SettleCycles = 10;
  localparam int BlockItems   = 70;
  localparam q_t QMax         = 32'sh7FFF_FFFF;
  localparam q_t QMin         = 32'sh8000_0000;
  localparam q_t One          = 32'sh0001_0000;

  logic             clk = 1'b0;
  logic             rst;
  logic             write_enable;
  logic [IdxW-1:0]  reg_index;
  logic [DataW-1:0] write_data;
  int               send_idle = 32;
  int               recv_idle = 63;
  int               idle_cycles = 0;
  int               samples_sent = 0;
  int               settings_loaded = 0;
  int               mismatches, drives_checked, clamped_low, clamped_high, outstanding;
  q_t               track_ref = '0;
  q_t               track_meas = '0;

  pidax_sample_if sample_bus();
  pidax_result_if result_bus();

  pid_axis_controller_top DUT (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample_bus),
    .result       (result_bus),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  pid_drive_checker drive_checker (
    .clk            (clk),
    .rst            (rst),
    .sample         (sample_bus),
    .result         (result_bus),
    .write_enable   (write_enable),
    .reg_index      (reg_index),
    .write_data     (write_data),
    .mismatches     (mismatches),
    .drives_checked (drives_checked),
    .clamped_low    (clamped_low),
    .clamped_high   (clamped_high),
    .outstanding    (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no beat moved for %0d cycles.", IdleLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic q_t fx(int whole);
    return q_t'(whole * 65536);
  endfunction

  function automatic q_t pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(4))
        0: return QMin;
        1: return QMax;
        2: return '0;
        3: return -1;
        default: return 1;
      endcase
    end else if (sel < 35) begin
      return q_t'($urandom);
    end
    return q_t'($urandom_range(0, 1 << 25)) - q_t'(1 << 24);
  endfunction

  function automatic q_t pick_gain();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      case ($urandom_range(4))
        0: return QMin;
        1: return QMax;
        2: return '0;
        3: return One;
        default: return -One;
      endcase
    end else if (sel < 35) begin
      return q_t'($urandom);
    end
    return q_t'($urandom_range(0, 1 << 19)) - q_t'(1 << 18);
  endfunction

  function automatic logic [31:0] pick_pole();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) begin
      return $urandom_range(0, 65536);
    end else if (sel < 60) begin
      return 32'd65536;
    end else if (sel < 70) begin
      return '0;
    end else if (sel < 85) begin
      return $urandom_range(65537, 131071);
    end
    return $urandom;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] kp, beta, pole, kd, ki, bias, lo, hi);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_SETPOINT_WEIGHT, beta);
    write_reg(REG_DERIV_POLE, pole);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_OUTPUT_BIAS, bias);
    write_reg(REG_DRIVE_MIN, lo);
    write_reg(REG_DRIVE_MAX, hi);
    write_enable <= 1'b0;
    settings_loaded++;
  endtask

  task automatic load_random_settings();
    q_t lo, hi;
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      lo = QMin;
      hi = QMax;
    end else if (sel < 30) begin
      lo = q_t'($urandom_range(1, 1 << 26));
      hi = -q_t'($urandom_range(0, 1 << 26));
    end else if (sel < 40) begin
      lo = q_t'($urandom);
      hi = q_t'($urandom);
    end else begin
      lo = -q_t'($urandom_range(1 << 16, 1 << 27));
      hi = q_t'($urandom_range(1 << 16, 1 << 27));
    end
    load_settings(pick_gain(), pick_gain(), pick_pole(), pick_gain(), pick_gain(),
                  pick_value(), lo, hi);
  endtask

  task automatic push_sample(input q_t r, input q_t m);
    while ($urandom_range(99) < send_idle) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.reference <= r;
    sample_bus.measurement <= m;
    do @(posedge clk); while (!sample_bus.ready);
    samples_sent++;
  endtask

  task automatic drain();
    sample_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic random_samples(input int count);
    q_t     r, m;
    longint step;
    int     sel;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 2) begin
        drain();
      end
      sel = $urandom_range(99);
      if (sel < 65) begin
        if ($urandom_range(19) == 0) begin
          track_ref = pick_value();
        end
        step = (longint'(track_ref) - longint'(track_meas)) / 8 +
               longint'($urandom_range(0, 8192)) - 4096;
        track_meas = q_t'(longint'(track_meas) + step);
        r = track_ref;
        m = track_meas;
      end else if (sel < 90) begin
        r = pick_value();
        m = pick_value();
      end else begin
        r = $urandom_range(1) ? QMax : QMin;
        m = $urandom_range(1) ? QMax : QMin;
      end
      push_sample(r, m);
    end
  endtask

  initial begin
    rst <= 1'b1;
    write_enable <= 1'b0;
    reg_index <= REG_PROP_GAIN;
    write_data <= '0;
    sample_bus.valid <= 1'b0;
    sample_bus.reference <= '0;
    sample_bus.measurement <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: unit proportional gain and setpoint weight, no integration, full-range limits.
    push_sample('0, '0);
    push_sample(QMax, QMin);
    push_sample(QMin, QMax);
    push_sample(QMax, QMax);
    push_sample(QMin, QMin);
    push_sample(One, -One);
    push_sample(1, 0);

    drain();
    load_settings(fx(2), 32'sh0000_8000, 32'd49152, 32'sh0001_8000, 32'sh0000_4000,
                  fx(10), fx(-100), fx(100));
    push_sample(fx(50), '0);
    push_sample(fx(-300), fx(200));
    push_sample(fx(300), fx(-200));
    push_sample('0, '0);
    push_sample('0, '0);
    push_sample(One, One);

    // Inverted limits and a pole written with every upper bit set.
    drain();
    load_settings(-One, '0, 32'hFFFF_FFFF, -One, QMax, '0, fx(5), fx(-5));
    push_sample('0, '0);
    push_sample(fx(10), '0);
    push_sample(fx(-10), '0);
    push_sample(QMax, QMin);
    push_sample(QMin, QMax);

    drain();
    load_settings(QMin, QMin, 32'd65536, QMin, QMin, QMax, QMin, QMax);
    push_sample(QMax, QMax);
    push_sample(QMin, QMin);
    push_sample(-1, 1);
    push_sample(1, -1);
    push_sample(QMax, QMin);
    push_sample('0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 32 : (phase == 1) ? 63 : 0;
      recv_idle = (phase == 0) ? 63 : (phase == 1) ? 32 : 0;
      for (int k = 0; k < 5; k++) begin
        drain();
        load_random_settings();
        random_samples(BlockItems);
      end
    end
    drain();

    $display("Covered %0d samples under %0d register settings with three idle patterns.",
             samples_sent, settings_loaded + 1);
    $display("Checked %0d drive beats: %0d clamped low, %0d clamped high.",
             drives_checked, clamped_low, clamped_high);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pidax_pkg.sv
hw/rtl/pidax_sample_if.sv
hw/rtl/pidax_result_if.sv
hw/rtl/pid_axis_controller_top.sv
verif/pid_drive_checker.sv
verif/pid_axis_controller_top_tb.sv
